// ===== rtl/core/bvd_pkg.sv =====
// ----------------------------------------------------------------------------
// bvd_pkg
// Shared types and constants of the beam Viterbi digit decoder.
// ----------------------------------------------------------------------------
package bvd_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int SYM_W       = 5;
    localparam logic [SYM_W-1:0] BREAK_SYM = 5'd26;
    localparam int MAX_LEN     = 1024;
    localparam int LEN_W       = 10;
    localparam int CNT_W       = 11;
    localparam int BEAM_MAX    = 8;
    localparam int BEAM_W      = 3;
    localparam int BCNT_W      = 4;
    localparam int GROUP_CAP   = 3;
    localparam int CAND_W      = 2;
    localparam int MAX_ORDER   = 3;
    localparam int TABLE_DEPTH = 17576;
    localparam int TIDX_W      = 15;
    localparam int TVAL_W      = 16;
    localparam int SCORE_W     = 32;
    localparam int BACK_DEPTH  = MAX_LEN * BEAM_MAX;
    localparam int BACK_DW     = SYM_W + BEAM_W;
    localparam int KEY_W       = 52;
    localparam int APB_AW      = 6;
    localparam int APB_DW      = 64;

    typedef enum logic [2:0] {
        KIND_LOAD   = 3'd0,
        KIND_START  = 3'd1,
        KIND_DIGIT  = 3'd2,
        KIND_FINISH = 3'd3,
        KIND_READ   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        REG_SEPARATOR = 3'd0,
        REG_ORDER     = 3'd1,
        REG_WIDTH     = 3'd2,
        REG_KEY_LOW   = 3'd3,
        REG_KEY_HIGH  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [3:0]       separator;
        logic [1:0]       ngram_order;
        logic [3:0]       beam_width;
        logic [KEY_W-1:0] key_low;
        logic [KEY_W-1:0] key_high;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIG,
        ST_SCAN,
        ST_SEL,
        ST_KEEP,
        ST_EXP_RD,
        ST_EXP_ADD,
        ST_EXP_INS,
        ST_NEW_WR,
        ST_BEST,
        ST_BT_RD,
        ST_BT_WR,
        ST_FIN_OUT,
        ST_RD_WAIT,
        ST_RD_OUT
    } t_state;

    typedef struct packed {
        logic table_wr;
        logic start_clear;
        logic capture;
        logic overflow_set;
        logic pos_inc;
        logic scan_init;
        logic scan_step;
        logic keep_init;
        logic keep_brk;
        logic keep_wr;
        logic exp_init;
        logic exp_add;
        logic exp_ins;
        logic new_wr;
        logic best_init;
        logic best_step;
        logic bt_init;
        logic bt_step;
        logic out_fin;
        logic out_rd;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic is_break;
        logic scan_last;
        logic nc_zero;
        logic keep_last;
        logic exp_last;
        logic new_last;
        logic best_done;
        logic pos_zero;
        logic bt_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/bvd_in_if.sv =====
// ----------------------------------------------------------------------------
// bvd_in_if
// Request channel into the decoder: valid/ready handshake and input fields.
// ----------------------------------------------------------------------------
interface bvd_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [14:0]        table_index;
    logic signed [15:0] table_value;
    logic [3:0]         digit;
    logic [9:0]         position;

    modport source (output valid, kind, table_index, table_value, digit, position,
                    input ready);
    modport sink (input valid, kind, table_index, table_value, digit, position,
                  output ready);
endinterface

// ===== rtl/core/bvd_out_if.sv =====
// ----------------------------------------------------------------------------
// bvd_out_if
// Result channel out of the decoder: valid/ready handshake and result fields.
// ----------------------------------------------------------------------------
interface bvd_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  symbol;
    logic [10:0] letter_count;
    logic        overflow;

    modport source (output valid, symbol, letter_count, overflow, input ready);
    modport sink (input valid, symbol, letter_count, overflow, output ready);
endinterface

// ===== rtl/core/bvd_ram.sv =====
// ----------------------------------------------------------------------------
// bvd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/bvd_regs.sv =====
// ----------------------------------------------------------------------------
// bvd_regs
// APB configuration registers: separator, order, beam width and letter key.
// ----------------------------------------------------------------------------
module bvd_regs
    import bvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator   <= 4'd0;
            r_cfg.ngram_order <= 2'd3;
            r_cfg.beam_width  <= 4'd8;
            r_cfg.key_low     <= '0;
            r_cfg.key_high    <= '0;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                REG_SEPARATOR: r_cfg.separator   <= pwdata[3:0];
                REG_ORDER:     r_cfg.ngram_order <= pwdata[1:0];
                REG_WIDTH:     r_cfg.beam_width  <= pwdata[3:0];
                REG_KEY_LOW:   r_cfg.key_low     <= pwdata[KEY_W-1:0];
                REG_KEY_HIGH:  r_cfg.key_high    <= pwdata[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_SEPARATOR: prdata = APB_DW'(r_cfg.separator);
            REG_ORDER:     prdata = APB_DW'(r_cfg.ngram_order);
            REG_WIDTH:     prdata = APB_DW'(r_cfg.beam_width);
            REG_KEY_LOW:   prdata = APB_DW'(r_cfg.key_low);
            REG_KEY_HIGH:  prdata = APB_DW'(r_cfg.key_high);
            default:       prdata = '0;
        endcase
    end
endmodule

// ===== rtl/core/bvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvd_ctrl
// Sequencer: takes requests and steps the datapath through each operation.
// ----------------------------------------------------------------------------
module bvd_ctrl
    import bvd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_kind,
    input  t_status    i_status,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_kind)
                        KIND_LOAD:   o_cmd.table_wr = 1'b1;
                        KIND_START:  o_cmd.start_clear = 1'b1;
                        KIND_DIGIT:  n_state = ST_DIG;
                        KIND_FINISH: begin
                            o_cmd.best_init = 1'b1;
                            n_state         = ST_BEST;
                        end
                        KIND_READ:   n_state = ST_RD_WAIT;
                        default: ;
                    endcase
                end
            end
            ST_DIG: begin
                if (i_status.full) begin
                    o_cmd.overflow_set = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    if (i_status.is_break) begin
                        o_cmd.keep_init = 1'b1;
                        o_cmd.keep_brk  = 1'b1;
                        n_state         = ST_KEEP;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_SEL;
                end
            end
            ST_SEL: begin
                if (i_status.nc_zero) begin
                    o_cmd.keep_init = 1'b1;
                    n_state         = ST_KEEP;
                end else begin
                    o_cmd.exp_init = 1'b1;
                    n_state        = ST_EXP_RD;
                end
            end
            ST_KEEP: begin
                o_cmd.keep_wr = 1'b1;
                if (i_status.keep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXP_RD: n_state = ST_EXP_ADD;
            ST_EXP_ADD: begin
                o_cmd.exp_add = 1'b1;
                n_state       = ST_EXP_INS;
            end
            ST_EXP_INS: begin
                o_cmd.exp_ins = 1'b1;
                n_state       = i_status.exp_last ? ST_NEW_WR : ST_EXP_RD;
            end
            ST_NEW_WR: begin
                o_cmd.new_wr = 1'b1;
                if (i_status.new_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BEST: begin
                if (!i_status.best_done) begin
                    o_cmd.best_step = 1'b1;
                end else begin
                    o_cmd.bt_init = 1'b1;
                    n_state       = i_status.pos_zero ? ST_FIN_OUT : ST_BT_RD;
                end
            end
            ST_BT_RD: n_state = ST_BT_WR;
            ST_BT_WR: begin
                o_cmd.bt_step = 1'b1;
                n_state       = i_status.bt_last ? ST_FIN_OUT : ST_BT_RD;
            end
            ST_FIN_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_fin = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_RD_WAIT: n_state = ST_RD_OUT;
            ST_RD_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_rd = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/bvd_dp.sv =====
// ----------------------------------------------------------------------------
// bvd_dp
// Datapath: beam registers, sorted insert, score table, back-pointer and
// decoded memories, result register.
// ----------------------------------------------------------------------------
module bvd_dp
    import bvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    input  logic [TIDX_W-1:0] i_table_index,
    input  logic [TVAL_W-1:0] i_table_value,
    input  logic [3:0]        i_digit,
    input  logic [LEN_W-1:0]  i_position,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [SYM_W-1:0]  o_symbol,
    output logic [CNT_W-1:0]  o_letter_count,
    output logic              o_overflow
);
    // persistent beam and message state
    logic [SCORE_W-1:0] r_bscore [BEAM_MAX];
    logic [SYM_W-1:0]   r_bh1    [BEAM_MAX];
    logic [SYM_W-1:0]   r_bh0    [BEAM_MAX];
    logic [BCNT_W-1:0]  r_bcount;
    logic [CNT_W-1:0]   r_pos_cnt;
    logic [CNT_W-1:0]   r_letters;
    logic [CNT_W-1:0]   r_dec_len;
    logic               r_ovf;
    logic               r_out_valid;

    // working registers
    logic [SCORE_W-1:0] r_ns   [BEAM_MAX];
    logic [SYM_W-1:0]   r_nh1  [BEAM_MAX];
    logic [SYM_W-1:0]   r_nh0  [BEAM_MAX];
    logic [BEAM_W-1:0]  r_nf   [BEAM_MAX];
    logic [SYM_W-1:0]   r_nsym [BEAM_MAX];
    logic [BCNT_W-1:0]  r_top;
    logic [SYM_W-1:0]   r_cand [GROUP_CAP];
    logic [CAND_W-1:0]  r_nc;
    logic [CAND_W-1:0]  r_c;
    logic [BCNT_W-1:0]  r_b;
    logic [SYM_W-1:0]   r_l;
    logic [3:0]         r_digit;
    logic [LEN_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_t;
    logic               r_keep_brk;
    logic [SCORE_W-1:0] r_sc;
    logic [SYM_W-1:0]   r_xsym;
    logic [SYM_W-1:0]   r_xh1;
    logic [SYM_W-1:0]   r_xh0;
    logic [BEAM_W-1:0]  r_xpar;
    logic [BEAM_W-1:0]  r_best;
    logic [SCORE_W-1:0] r_best_sc;
    logic [CNT_W-1:0]   r_bt;
    logic [CNT_W-1:0]   r_fcnt;
    logic [BEAM_W-1:0]  r_cur;
    logic [SYM_W-1:0]   r_out_sym;
    logic [CNT_W-1:0]   r_out_cnt;
    logic               r_out_ovf;

    logic [3:0]         w_bw;
    logic [1:0]         w_ord;
    logic               w_addwin;
    logic [3:0]         w_group;
    logic [3:0]         w_grp [NUM_LETTERS];
    logic [BEAM_W-1:0]  w_bi;
    logic [SYM_W-1:0]   w_x;
    logic [TIDX_W-1:0]  w_widx;
    logic [TVAL_W-1:0]  w_tab_rd;
    logic [SCORE_W-1:0] w_win;
    logic [BEAM_MAX-1:0] w_ge;
    logic [BCNT_W-1:0]  w_k;
    logic               w_ins;
    logic               w_tab_we;
    logic               w_back_we;
    logic [BACK_DW-1:0] w_back_wd;
    logic [BACK_DW-1:0] w_back_rd;
    logic [CNT_W-1:0]   w_bt_m1;
    logic [SYM_W-1:0]   w_bt_sym;
    logic [SYM_W-1:0]   w_dec_rd;
    logic               w_new_last;
    logic               w_keep_last;

    assign w_bw  = (i_cfg.beam_width == 4'd0) ? 4'd1 :
                   (i_cfg.beam_width > BCNT_W'(BEAM_MAX)) ? BCNT_W'(BEAM_MAX) :
                   i_cfg.beam_width;
    assign w_ord = (i_cfg.ngram_order == 2'd0) ? 2'd1 : i_cfg.ngram_order;
    assign w_addwin = r_letters >= CNT_W'(w_ord - 2'd1);
    assign w_group  = (i_cfg.separator < r_digit) ? r_digit - 4'd1 : r_digit;

    always_comb begin
        for (int l = 0; l < NUM_LETTERS; l++) begin
            if (l < 13) begin
                w_grp[l] = i_cfg.key_low[4*l +: 4];
            end else begin
                w_grp[l] = i_cfg.key_high[4*(l-13) +: 4];
            end
        end
    end

    // candidate window address: older letter, newer letter, new letter
    assign w_bi   = r_b[BEAM_W-1:0];
    assign w_x    = r_cand[r_c];
    assign w_widx = TIDX_W'(r_bh1[w_bi]) * TIDX_W'(676) +
                    TIDX_W'(r_bh0[w_bi]) * TIDX_W'(26) + TIDX_W'(w_x);
    assign w_win  = w_addwin ? {{(SCORE_W-TVAL_W){w_tab_rd[TVAL_W-1]}}, w_tab_rd} : '0;

    // insert rank: entries scoring at least as high stay ahead
    always_comb begin
        w_k = '0;
        for (int j = 0; j < BEAM_MAX; j++) begin
            w_ge[j] = (BCNT_W'(j) < r_top) && !($signed(r_sc) > $signed(r_ns[j]));
            w_k     = w_k + BCNT_W'(w_ge[j]);
        end
    end
    assign w_ins = (r_top < w_bw) || (w_k < w_bw);

    assign w_new_last  = r_b == r_top - 4'd1;
    assign w_keep_last = r_b == r_bcount - 4'd1;
    assign w_bt_m1     = r_bt - 11'd1;
    assign w_bt_sym    = w_back_rd[BACK_DW-1:BEAM_W];

    assign w_tab_we  = i_cmd.table_wr && (i_table_index < TIDX_W'(TABLE_DEPTH));
    assign w_back_we = i_cmd.keep_wr || i_cmd.new_wr;
    assign w_back_wd = i_cmd.keep_wr ? {(r_keep_brk ? BREAK_SYM : '0), w_bi}
                                     : {r_nsym[w_bi], r_nf[w_bi]};

    bvd_ram #(.WIDTH(TVAL_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (w_widx),
        .o_rdata (w_tab_rd)
    );

    bvd_ram #(.WIDTH(BACK_DW), .DEPTH(BACK_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_we    (w_back_we),
        .i_waddr ({r_t, w_bi}),
        .i_wdata (w_back_wd),
        .i_raddr ({w_bt_m1[LEN_W-1:0], r_cur}),
        .o_rdata (w_back_rd)
    );

    bvd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_decoded (
        .i_clk   (i_clk),
        .i_we    (i_cmd.bt_step),
        .i_waddr (w_bt_m1[LEN_W-1:0]),
        .i_wdata (w_bt_sym),
        .i_raddr (r_pos),
        .o_rdata (w_dec_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start_clear) begin
            for (int j = 0; j < BEAM_MAX; j++) begin
                r_bscore[j] <= '0;
                r_bh1[j]    <= '0;
                r_bh0[j]    <= '0;
            end
            r_bcount  <= 4'd1;
            r_pos_cnt <= '0;
            r_letters <= '0;
            r_dec_len <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.overflow_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.pos_inc) begin
                r_pos_cnt <= r_pos_cnt + 11'd1;
            end
            if (i_cmd.keep_wr && w_keep_last && !r_keep_brk) begin
                r_letters <= r_letters + 11'd1;
            end
            if (i_cmd.new_wr && w_new_last) begin
                for (int j = 0; j < BEAM_MAX; j++) begin
                    r_bscore[j] <= r_ns[j];
                    r_bh1[j]    <= r_nh1[j];
                    r_bh0[j]    <= r_nh0[j];
                end
                r_bcount  <= r_top;
                r_letters <= r_letters + 11'd1;
            end
            if (i_cmd.bt_init) begin
                r_dec_len <= r_pos_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_fin || i_cmd.out_rd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_digit <= i_digit;
            r_pos   <= i_position;
        end
        if (i_cmd.pos_inc) begin
            r_t <= r_pos_cnt[LEN_W-1:0];
        end
        if (i_cmd.scan_init) begin
            r_l  <= '0;
            r_nc <= '0;
        end
        if (i_cmd.scan_step) begin
            if (w_grp[r_l] == w_group && r_nc < CAND_W'(GROUP_CAP)) begin
                r_cand[r_nc] <= r_l;
                r_nc         <= r_nc + 2'd1;
            end
            r_l <= r_l + 5'd1;
        end
        if (i_cmd.keep_init) begin
            r_b        <= '0;
            r_keep_brk <= i_cmd.keep_brk;
        end
        if (i_cmd.keep_wr || i_cmd.new_wr) begin
            r_b <= r_b + 4'd1;
        end
        if (i_cmd.exp_init) begin
            r_b   <= '0;
            r_c   <= '0;
            r_top <= '0;
        end
        if (i_cmd.exp_add) begin
            r_sc   <= r_bscore[w_bi] + w_win;
            r_xsym <= w_x;
            r_xh1  <= (w_ord == 2'd3) ? r_bh0[w_bi] : '0;
            r_xh0  <= (w_ord >= 2'd2) ? w_x : '0;
            r_xpar <= w_bi;
        end
        if (i_cmd.exp_ins) begin
            for (int j = 0; j < BEAM_MAX; j++) begin
                if (w_ins && BCNT_W'(j) == w_k) begin
                    r_ns[j]   <= r_sc;
                    r_nh1[j]  <= r_xh1;
                    r_nh0[j]  <= r_xh0;
                    r_nf[j]   <= r_xpar;
                    r_nsym[j] <= r_xsym;
                end
            end
            for (int j = 1; j < BEAM_MAX; j++) begin
                if (w_ins && BCNT_W'(j) > w_k) begin
                    r_ns[j]   <= r_ns[j-1];
                    r_nh1[j]  <= r_nh1[j-1];
                    r_nh0[j]  <= r_nh0[j-1];
                    r_nf[j]   <= r_nf[j-1];
                    r_nsym[j] <= r_nsym[j-1];
                end
            end
            if (w_ins && r_top < w_bw) begin
                r_top <= r_top + 4'd1;
            end
            if (r_c == r_nc - 2'd1) begin
                r_c <= '0;
                r_b <= o_status.exp_last ? '0 : r_b + 4'd1;
            end else begin
                r_c <= r_c + 2'd1;
            end
        end
        if (i_cmd.best_init) begin
            r_b       <= 4'd1;
            r_best    <= '0;
            r_best_sc <= r_bscore[0];
        end
        if (i_cmd.best_step) begin
            if ($signed(r_bscore[w_bi]) > $signed(r_best_sc)) begin
                r_best    <= w_bi;
                r_best_sc <= r_bscore[w_bi];
            end
            r_b <= r_b + 4'd1;
        end
        if (i_cmd.bt_init) begin
            r_bt   <= r_pos_cnt;
            r_fcnt <= '0;
            r_cur  <= r_best;
        end
        if (i_cmd.bt_step) begin
            if (w_bt_sym != BREAK_SYM) begin
                r_fcnt <= r_fcnt + 11'd1;
            end
            r_cur <= w_back_rd[BEAM_W-1:0];
            r_bt  <= w_bt_m1;
        end
        if (i_cmd.out_fin) begin
            r_out_sym <= '0;
            r_out_cnt <= r_fcnt;
            r_out_ovf <= r_ovf;
        end
        if (i_cmd.out_rd) begin
            r_out_sym <= (CNT_W'(r_pos) < r_dec_len) ? w_dec_rd : BREAK_SYM;
            r_out_cnt <= '0;
            r_out_ovf <= 1'b0;
        end
    end

    always_comb begin
        o_status.full      = r_pos_cnt == CNT_W'(MAX_LEN);
        o_status.is_break  = (r_digit > 4'd9) || (r_digit == i_cfg.separator);
        o_status.scan_last = r_l == SYM_W'(NUM_LETTERS - 1);
        o_status.nc_zero   = r_nc == '0;
        o_status.keep_last = w_keep_last;
        o_status.exp_last  = (r_c == r_nc - 2'd1) && (r_b == r_bcount - 4'd1);
        o_status.new_last  = w_new_last;
        o_status.best_done = r_b >= r_bcount;
        o_status.pos_zero  = r_pos_cnt == '0;
        o_status.bt_last   = r_bt == 11'd1;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_letter_count = r_out_cnt;
    assign o_overflow     = r_out_ovf;
endmodule

// ===== rtl/core/beam_viterbi_digit_decoder.sv =====
// load table word, start message, unknown kind: handled in the idle state, ready again next cycle
// digit: scan of all 26 letters, then one table read and one sorted insert per (beam entry x
//   candidate), then the new beam is written back
// finish: best-entry search over the beam, then one back-pointer step per stored position; read position: memory read
// a waiting result holds off only the next finish or read, other requests go on
// synchronous active-low reset: one zero beam entry, counters and registers to defaults
// ----------------------------------------------------------------------------
// beam_viterbi_digit_decoder
// Beam-search Viterbi decoder of a digit cipher with an n-gram score table.
// ----------------------------------------------------------------------------
module beam_viterbi_digit_decoder
    import bvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bvd_in_if.sink            i_in,
    bvd_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    bvd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_status   (w_status),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    bvd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .i_table_index  (i_in.table_index),
        .i_table_value  (i_in.table_value),
        .i_digit        (i_in.digit),
        .i_position     (i_in.position),
        .i_out_ready    (o_out.ready),
        .o_status       (w_status),
        .o_out_valid    (o_out.valid),
        .o_symbol       (o_out.symbol),
        .o_letter_count (o_out.letter_count),
        .o_overflow     (o_out.overflow)
    );
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the beam Viterbi digit decoder: loads the score
// table, walks a directed table, then random messages over several register
// settings. Results are checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
    import bvd_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int         STALL_LIMIT   = 40000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 150;

    typedef struct packed {
        logic [4:0]  sym;
        logic [10:0] cnt;
        logic        ovf;
    } t_decode;

    typedef struct {
        logic [2:0] kind;
        int         idx;
        int         val;
        int         dig;
        int         pos;
        bit         typed;
        t_decode    want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;
    logic              pready;

    bvd_in_if  in_ch();
    bvd_out_if out_ch();

    beam_viterbi_digit_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [3:0]       sep_r;
    logic [1:0]       order_r;
    logic [3:0]       width_r;
    logic [KEY_W-1:0] key_lo_r, key_hi_r;
    logic [15:0]      score_tbl [TABLE_DEPTH];
    logic [9:0]       hist [BEAM_MAX];
    logic [31:0]      score [BEAM_MAX];
    int               beam_n;
    logic [4:0]       back_sym [BACK_DEPTH];
    logic [2:0]       back_par [BACK_DEPTH];
    logic [4:0]       decoded [MAX_LEN];
    int               decoded_len, pos_count, letters;
    bit               ovf_flag;

    t_decode pending[$];
    t_row    rows[$];
    int      errors = 0;
    bit      quiet;
    int      hold_req;
    int      hold_done = 0;
    int      hold_left = 0;
    int      stall = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [3:0] group_of(int l);
        return (l < 13) ? key_lo_r[4*l +: 4] : key_hi_r[4*(l-13) +: 4];
    endfunction

    function automatic logic [31:0] tbl_word(int a);
        return {{16{score_tbl[a][15]}}, score_tbl[a]};
    endfunction

    task automatic clear_message();
        for (int b = 0; b < BEAM_MAX; b++) begin
            hist[b] = '0;
            score[b] = '0;
        end
        beam_n = 1;
        pos_count = 0;
        letters = 0;
        ovf_flag = 0;
        decoded_len = 0;
    endtask

    task automatic extend_beam(logic [3:0] d);
        int t, nc, g, top, bw, n, pw, p, widx;
        int cand[GROUP_CAP];
        logic [9:0]  nh[BEAM_MAX];
        logic [31:0] ns[BEAM_MAX];
        int          nf[BEAM_MAX];
        logic [4:0]  nsym[BEAM_MAX];
        logic [31:0] sc;
        bit addwin;
        t = pos_count;
        nc = 0;
        top = 0;
        pw = 1;
        if (t >= MAX_LEN) begin
            ovf_flag = 1;
            return;
        end
        pos_count = t + 1;
        if (d > 9 || d == sep_r) begin
            for (int b = 0; b < beam_n; b++) begin
                back_sym[t*BEAM_MAX+b] = BREAK_SYM;
                back_par[t*BEAM_MAX+b] = b[2:0];
            end
            return;
        end
        g = (sep_r < d) ? d - 1 : d;
        for (int l = 0; l < NUM_LETTERS; l++)
            if (group_of(l) == g && nc < GROUP_CAP) begin
                cand[nc] = l;
                nc++;
            end
        if (nc == 0) begin
            // no candidate letter: filler, beam untouched
            for (int b = 0; b < beam_n; b++) begin
                back_sym[t*BEAM_MAX+b] = '0;
                back_par[t*BEAM_MAX+b] = b[2:0];
            end
            letters++;
            return;
        end
        bw = (width_r < 1) ? 1 : (width_r > BEAM_MAX) ? BEAM_MAX : width_r;
        n = (order_r < 1) ? 1 : (order_r > MAX_ORDER) ? MAX_ORDER : order_r;
        for (int i = 1; i < n; i++) pw *= NUM_LETTERS;
        addwin = letters >= n - 1;
        for (int b = 0; b < beam_n; b++) begin
            for (int c = 0; c < nc; c++) begin
                widx = hist[b] * NUM_LETTERS + cand[c];
                sc = score[b] + (addwin ? tbl_word(widx) : 32'd0);
                if (top < bw) begin
                    p = top;
                    top++;
                end else if ($signed(sc) > $signed(ns[bw-1])) begin
                    p = bw - 1;
                end else begin
                    continue;
                end
                // sorted insert, earlier entry wins a tie
                while (p > 0 && $signed(sc) > $signed(ns[p-1])) begin
                    ns[p] = ns[p-1];
                    nh[p] = nh[p-1];
                    nf[p] = nf[p-1];
                    nsym[p] = nsym[p-1];
                    p--;
                end
                ns[p] = sc;
                nh[p] = 10'(widx % pw);
                nf[p] = b;
                nsym[p] = 5'(cand[c]);
            end
        end
        for (int b = 0; b < top; b++) begin
            hist[b] = nh[b];
            score[b] = ns[b];
            back_sym[t*BEAM_MAX+b] = nsym[b];
            back_par[t*BEAM_MAX+b] = nf[b][2:0];
        end
        beam_n = top;
        letters++;
    endtask

    function automatic int backtrack();
        int best, b, k, count;
        best = 0;
        count = 0;
        for (int i = 1; i < beam_n; i++)
            if ($signed(score[i]) > $signed(score[best])) best = i;
        b = best;
        for (int t = pos_count; t > 0; t--) begin
            k = (t - 1) * BEAM_MAX + (b % BEAM_MAX);
            decoded[t-1] = back_sym[k];
            if (back_sym[k] != BREAK_SYM) count++;
            b = back_par[k];
        end
        decoded_len = pos_count;
        return count;
    endfunction

    task automatic predict_request(logic [2:0] k, int idx, int val, int dig, int pos,
                                   output bit has, output t_decode res);
        has = 0;
        res = '0;
        case (k)
            KIND_LOAD: if (idx < TABLE_DEPTH) score_tbl[idx] = val[15:0];
            KIND_START: clear_message();
            KIND_DIGIT: extend_beam(dig[3:0]);
            KIND_FINISH: begin
                res.cnt = 11'(backtrack());
                res.ovf = ovf_flag;
                has = 1;
            end
            KIND_READ: begin
                res.sym = (pos < decoded_len) ? decoded[pos] : BREAK_SYM;
                has = 1;
            end
            default: ;
        endcase
    endtask

    task automatic send(logic [2:0] k, int idx, int val, int dig, int pos,
                        bit typed = 0, t_decode want = '0);
        bit has;
        t_decode res;
        while (!quiet && $urandom_range(99) < 11) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= k;
        in_ch.table_index <= idx[14:0];
        in_ch.table_value <= val[15:0];
        in_ch.digit       <= dig[3:0];
        in_ch.position    <= pos[9:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_request(k, idx, val, dig, pos, has, res);
        if (has) pending.push_back(typed ? want : res);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx r, logic [63:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(8 * r);
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_SEPARATOR: sep_r    = v[3:0];
            REG_ORDER:     order_r  = v[1:0];
            REG_WIDTH:     width_r  = v[3:0];
            REG_KEY_LOW:   key_lo_r = v[KEY_W-1:0];
            REG_KEY_HIGH:  key_hi_r = v[KEY_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < 13; i++) v[4*i +: 4] = 4'($urandom_range(0, 11));
        return v;
    endfunction

    task automatic setup(int sep, int ord, int bw, logic [63:0] klo, logic [63:0] khi);
        reg_write(REG_SEPARATOR, sep);
        reg_write(REG_ORDER, ord);
        reg_write(REG_WIDTH, bw);
        reg_write(REG_KEY_LOW, klo);
        reg_write(REG_KEY_HIGH, khi);
    endtask

    function automatic void row(logic [2:0] k, int idx, int val, int dig, int pos,
                                bit typed = 0, int sym = 0, int cnt = 0, int ovf = 0);
        t_row r;
        r.kind = k;
        r.idx = idx;
        r.val = val;
        r.dig = dig;
        r.pos = pos;
        r.typed = typed;
        r.want = '{sym: 5'(sym), cnt: 11'(cnt), ovf: 1'(ovf)};
        rows.push_back(r);
    endfunction

    task automatic random_message(int items);
        int r, d;
        send(KIND_START, 0, 0, 0, 0);
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 68) begin
                d = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(9);
                send(KIND_DIGIT, $urandom_range(32767), $urandom, d, $urandom_range(1023));
            end else if (r < 74) begin
                send(KIND_LOAD, $urandom_range(32767), $urandom, $urandom_range(15), 0);
            end else if (r < 79) begin
                send(KIND_FINISH, 0, 0, 0, 0);
            end else if (r < 81) begin
                send(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 0, 0, 0, 0);
            end else if (r < 83) begin
                send(KIND_START, 0, 0, 0, 0);
            end else if (r < 93) begin
                send(KIND_READ, 0, 0, 0, $urandom_range(pos_count + 2));
            end else begin
                send(KIND_READ, 0, 0, 0, $urandom_range(1023));
            end
        end
        send(KIND_FINISH, 0, 0, 0, 0);
        for (int p = 0; p < pos_count && p < 6; p++) send(KIND_READ, 0, 0, 0, p);
    endtask

    // result side: checks and back-pressure
    always @(posedge i_clk) begin
        t_decode want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending.size() == 0) begin
                $display("%0t unexpected result sym=%0d cnt=%0d ovf=%0d", $time,
                         out_ch.symbol, out_ch.letter_count, out_ch.overflow);
                errors++;
            end else begin
                want = pending.pop_front();
                if (out_ch.symbol !== want.sym) begin
                    $display("%0t symbol expected %0d got %0d", $time, want.sym,
                             out_ch.symbol);
                    errors++;
                end
                if (out_ch.letter_count !== want.cnt) begin
                    $display("%0t letter_count expected %0d got %0d", $time, want.cnt,
                             out_ch.letter_count);
                    errors++;
                end
                if (out_ch.overflow !== want.ovf) begin
                    $display("%0t overflow expected %0d got %0d", $time, want.ovf,
                             out_ch.overflow);
                    errors++;
                end
            end
        end
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= quiet || ($urandom_range(99) >= 11);
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            stall <= 0;
        end else if (stall >= STALL_LIMIT) begin
            $display("FAIL beam_viterbi_digit_decoder");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

    initial begin
        quiet = 0;
        hold_req = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_LOAD;
        in_ch.table_index <= '0;
        in_ch.table_value <= '0;
        in_ch.digit <= '0;
        in_ch.position <= '0;
        sep_r = 4'd0;
        order_r = 2'd3;
        width_r = 4'd8;
        key_lo_r = '0;
        key_hi_r = '0;
        clear_message();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every window read must hit a written word, so fill the table first
        quiet = 1;
        for (int a = 0; a < TABLE_DEPTH; a++) send(KIND_LOAD, a, $urandom, 0, 0);
        quiet = 0;

        row(KIND_FINISH, 0, 0, 0, 0, 1, 0, 0, 0);
        row(KIND_READ, 0, 0, 0, 0, 1, BREAK_SYM, 0, 0);
        row(KIND_READ, 0, 0, 0, 1023, 1, BREAK_SYM, 0, 0);
        row(KIND_LOAD, TABLE_DEPTH, 16'h7fff, 0, 0);
        row(KIND_LOAD, 32767, 16'h8000, 0, 0);
        row(KIND_LOAD, 0, 16'h8000, 0, 0);
        row(KIND_LOAD, TABLE_DEPTH - 1, 16'h7fff, 0, 0);
        row(KIND_SPARE_LO, 0, 0, 0, 0);
        row(KIND_SPARE_LO + 3'd1, 0, 0, 0, 0);
        row(KIND_SPARE_HI, 0, 0, 0, 0);
        row(KIND_DIGIT, 0, 0, 0, 0);
        row(KIND_DIGIT, 0, 0, 15, 0);
        row(KIND_DIGIT, 0, 0, 1, 0);
        row(KIND_DIGIT, 0, 0, 9, 0);
        row(KIND_DIGIT, 0, 0, 1, 0);
        row(KIND_DIGIT, 0, 0, 1, 0);
        row(KIND_DIGIT, 0, 0, 10, 0);
        row(KIND_FINISH, 0, 0, 0, 0);
        row(KIND_READ, 0, 0, 0, 0);
        row(KIND_READ, 0, 0, 0, 2);
        row(KIND_READ, 0, 0, 0, 5);
        row(KIND_READ, 0, 0, 0, 7, 1, BREAK_SYM, 0, 0);
        row(KIND_START, 0, 0, 0, 0);
        row(KIND_FINISH, 0, 0, 0, 0, 1, 0, 0, 0);
        foreach (rows[i])
            send(rows[i].kind, rows[i].idx, rows[i].val, rows[i].dig, rows[i].pos,
                 rows[i].typed, rows[i].want);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            setup((ph == 0) ? 0 : (ph == 1) ? 9 : $urandom_range(15),
                  ph % 4,
                  (ph == 0) ? 1 : (ph == 1) ? 8 : (ph == 2) ? 0 : (ph == 3) ? 15
                      : $urandom_range(1, 8),
                  (ph == 2) ? 64'hf_ffff_ffff_ffff : (ph == 5) ? 64'd0 : rand_key(),
                  (ph == 2) ? 64'hf_ffff_ffff_ffff : rand_key());
            quiet = (ph == 3);
            if (ph == 1) hold_req++;
            random_message(110);
            if (ph == 4) drain();
            random_message(110);
            drain();
        end
        quiet = 0;

        // long message past capacity
        setup(0, 2, 1, rand_key(), rand_key());
        send(KIND_START, 0, 0, 0, 0);
        for (int i = 0; i < MAX_LEN + 6; i++) send(KIND_DIGIT, 0, 0, $urandom_range(15), 0);
        send(KIND_FINISH, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, MAX_LEN - 1);
        send(KIND_READ, 0, 0, 0, $urandom_range(1023));
        drain();

        if (errors == 0) begin
            $display("PASS beam_viterbi_digit_decoder");
        end else begin
            $display("FAIL beam_viterbi_digit_decoder");
        end
        $finish;
    end

endmodule
